// ----- hw/rtl/lwu_pkg.sv -----
// Package for the LEDBAT window update block.
// Holds shared widths, reset values, register indexes and the sequencer states.
// No dependencies.
package lwu_pkg;

  // Default sizing of the top level.
  localparam int unsigned SEND_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned FILTER_DEPTH_DEF     = 16;
  localparam int unsigned TIME_WIDTH_DEF       = 48;

  // Fixed field widths.
  localparam int unsigned PSN_W    = 24;
  localparam int unsigned CWND_W   = 40;
  localparam int unsigned TGT_W    = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MINC_W   = 10;
  localparam int unsigned FLEN_W   = 5;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned PS_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 40;

  // Derived arithmetic widths.
  localparam int unsigned GP_W     = GAIN_W + PS_W;       // gain * packet size
  localparam int unsigned REF_W    = TGT_W + 1;           // target + base delay
  localparam int unsigned DEN_W    = TGT_W + 8 + CWND_W;  // (target << 8) * packets
  localparam int unsigned FLOOR_W  = MINC_W + PS_W;
  localparam int unsigned DELTA_W  = 42;                  // holds the clamp value
  localparam int unsigned NEXT_W   = 42;
  localparam int unsigned PKNUM_W  = CWND_W + 1;          // cwnd + ps - 1

  // Multiplier: second operand consumed one byte per cycle.
  localparam int unsigned MUL_B_W   = 40;
  localparam int unsigned MUL_CHUNK = 8;
  localparam int unsigned MUL_STEPS = MUL_B_W / MUL_CHUNK;

  // Delta magnitude clamp, 2^41.
  localparam logic [DELTA_W-1:0] DELTA_CLAMP = DELTA_W'(1) << 41;
  localparam logic [CWND_W-1:0]  CWND_MAX    = '1;

  // Register reset values.
  localparam logic [TGT_W-1:0]  TARGET_RST = 32'd100000000;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;
  localparam logic [MINC_W-1:0] MINC_RST   = 10'd2;
  localparam logic [FLEN_W-1:0] FLEN_RST   = 5'd4;
  localparam logic [BASE_W-1:0] BASE_RST   = 32'd0;
  localparam logic [PS_W-1:0]   PS_RST     = 16'd1024;
  localparam logic [CWND_W-1:0] INIT_RST   = 40'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_MINC   = 3'd2,
    CFG_FLEN   = 3'd3,
    CFG_BASE   = 3'd4,
    CFG_PS     = 3'd5,
    CFG_INIT   = 3'd6
  } cfg_idx_e;

  // Request kinds.
  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_ACK  = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ACCESS,
    ST_SENDRD,
    ST_SCAN,
    ST_PKTS_GO,
    ST_PKTS,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/lwu_div.sv -----
// Restoring divider, one quotient bit per cycle, for the window update block.
// Numerator is left aligned by the caller; the iteration count is an input.
// Depends on lwu_pkg only through the instantiating module.
module lwu_div #(
  parameter int unsigned DW  = 81,
  parameter int unsigned ITW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [ITW-1:0] iters_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  logic [DW-1:0]  n_q, n_d, d_q, d_d, q_q, q_d, r_q, r_d;
  logic [ITW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;
  logic [DW:0]    trial;

  // One shift, compare and subtract per cycle.
  always_comb begin
    n_d    = n_q;
    d_d    = d_q;
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, n_q[DW-1]};
    if (start_i) begin
      n_d    = num_i;
      d_d    = den_i;
      q_d    = '0;
      r_d    = '0;
      cnt_d  = iters_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, d_q}) begin
        r_d = DW'(trial - {1'b0, d_q});
        q_d = {q_q[DW-2:0], 1'b1};
      end else begin
        r_d = trial[DW-1:0];
        q_d = {q_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - ITW'(1);
      if (cnt_q == ITW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    q_q <= q_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

// ----- hw/rtl/lwu_mul.sv -----
// Iterative multiplier for the window update block: one byte of the second
// operand per cycle. Depends on lwu_pkg for the operand layout.
module lwu_mul #(
  parameter int unsigned AW = 81
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [AW-1:0]             a_i,
  input  logic [lwu_pkg::MUL_B_W-1:0] b_i,
  output logic                      done_o,
  output logic [AW-1:0]             prod_o
);

  localparam int unsigned SW = $clog2(lwu_pkg::MUL_STEPS + 1);

  logic [AW-1:0]               a_q, acc_q;
  logic [lwu_pkg::MUL_B_W-1:0] b_q;
  logic [SW-1:0]               cnt_q;
  logic                        busy_q, done_q;
  logic [AW-1:0]               pp;

  // Partial product of the shifted operand and the low byte.
  assign pp = AW'(a_q * b_q[lwu_pkg::MUL_CHUNK-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SW'(lwu_pkg::MUL_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - SW'(1);
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Accumulate byte by byte.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= a_q << lwu_pkg::MUL_CHUNK;
      b_q   <= b_q >> lwu_pkg::MUL_CHUNK;
      acc_q <= acc_q + pp;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- hw/rtl/ledbat_window_update_top.sv -----
// Top level of the LEDBAT window update block.
// Depends on lwu_pkg, lwu_div and lwu_mul.
//
// Usage: a send request (func 0) stores now_ns in the send table slot of its
// sequence number and gives no result. An ACK request (func 1) reads the send
// time of sequence psn-1, forms one-way delay and RTT, runs the delay through
// the min filter and updates the congestion window; it gives one result with
// cwnd_bytes, rtt_ns and filtered_delay_ns.
// Channels: requests enter on in_valid_i/in_stall_o, results leave on
// out_valid_o/out_stall_i, registers are written on cfg_valid_i/cfg_ready_o.
// Sequence: a send writes its table slot. An ACK reads its send time, walks
// the filter, divides for the packet count, runs two multiplications and a
// window division (numerator NUMW = TIME_WIDTH + 33 bits) and updates the
// window. Both kinds first take the slot modulo on the shared divider when
// the depth is not a power of two; all divisions run on it one at a time.
// A finished result sits in an output register; when the receiver stalls, the
// next request is still accepted and runs until its own result is ready.
// Reset clears control state and loads the register reset values, with the
// window at initial_cwnd_bytes. The send table and the filter memory are not
// cleared.
module ledbat_window_update_top #(
  parameter int unsigned SEND_TABLE_DEPTH = lwu_pkg::SEND_TABLE_DEPTH_DEF,
  parameter int unsigned FILTER_DEPTH     = lwu_pkg::FILTER_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH       = lwu_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [lwu_pkg::PSN_W-1:0]         psn_i,
  input  logic [TIME_WIDTH-1:0]             now_ns_i,
  input  logic [TIME_WIDTH-1:0]             ack_stamp_ns_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lwu_pkg::CWND_W-1:0]        cwnd_bytes_o,
  output logic [TIME_WIDTH-1:0]             rtt_ns_o,
  output logic [TIME_WIDTH-1:0]             filtered_delay_ns_o,
  // Configuration channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lwu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lwu_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned IW    = $clog2(SEND_TABLE_DEPTH);
  localparam int unsigned HW    = (FILTER_DEPTH > 2) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned CW    = HW;
  localparam int unsigned MAGW  = TIME_WIDTH + 1;
  localparam int unsigned NUMW  = MAGW + lwu_pkg::GP_W;
  localparam int unsigned DW    = (NUMW > lwu_pkg::DEN_W) ? NUMW : lwu_pkg::DEN_W;
  localparam int unsigned ITW   = $clog2(DW + 1);
  localparam bit          POW2  = (SEND_TABLE_DEPTH & (SEND_TABLE_DEPTH - 1)) == 0;

  // Configuration registers.
  logic [lwu_pkg::TGT_W-1:0]  target_q;
  logic [lwu_pkg::GAIN_W-1:0] gain_q;
  logic [lwu_pkg::MINC_W-1:0] minc_q;
  logic [lwu_pkg::FLEN_W-1:0] flen_q;
  logic [lwu_pkg::BASE_W-1:0] base_q;
  logic [lwu_pkg::PS_W-1:0]   ps_q;

  // Sequencer and working registers.
  lwu_pkg::state_e state_q, state_d;
  logic                       func_q, func_d;
  logic [lwu_pkg::PSN_W-1:0]  psn_val;
  logic [TIME_WIDTH-1:0]      now_q, now_d, stamp_q, stamp_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic [TIME_WIDTH-1:0]      rtt_q, rtt_d, best_q, best_d;
  logic [HW-1:0]              head_q, head_d, wbase_q, wbase_d;
  logic [CW-1:0]              cnt_q, cnt_d, scan_q, scan_d;
  logic                       pend_q, pend_d;
  logic [lwu_pkg::CWND_W-1:0] pkts_q, pkts_d;
  logic [lwu_pkg::GP_W-1:0]   gp_q, gp_d;
  logic [MAGW-1:0]            mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic [DW-1:0]              num_q, num_d;
  logic [lwu_pkg::FLOOR_W-1:0] floor_q, floor_d;
  logic [lwu_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [lwu_pkg::CWND_W-1:0] cwnd_q, cwnd_d;
  logic                       out_valid_q, out_load;
  logic [lwu_pkg::CWND_W-1:0] out_cwnd_q;
  logic [TIME_WIDTH-1:0]      out_rtt_q, out_filt_q;

  // Memories and their ports.
  logic [TIME_WIDTH-1:0] send_mem [SEND_TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] win_mem  [FILTER_DEPTH];
  logic [TIME_WIDTH-1:0] send_rd_q, win_rd_q;
  logic                  send_we, send_re, win_we;
  logic [HW-1:0]         win_raddr;

  // Shared arithmetic units.
  logic                        div_start, div_done, mul_start, mul_done;
  logic [DW-1:0]               div_n, div_d, div_q, div_r, mul_a, mul_p;
  logic [ITW-1:0]              div_iters;
  logic [lwu_pkg::MUL_B_W-1:0] mul_b;

  // Helper values.
  logic                        accept;
  logic [lwu_pkg::TGT_W-1:0]   tgt_eff;
  logic [lwu_pkg::PS_W-1:0]    ps_eff;
  logic [TIME_WIDTH-1:0]       delay_w, rtt_w;
  logic [6:0]                  len7;
  logic [CW:0]                 keep, cnt_inc;
  logic [lwu_pkg::REF_W-1:0]   ref_w;
  logic [lwu_pkg::PKNUM_W-1:0] pk_num;
  logic [lwu_pkg::NEXT_W-1:0]  next_w, floor_ext;

  lwu_div #(.DW(DW), .ITW(ITW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  lwu_mul #(.AW(DW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != lwu_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign tgt_eff     = (target_q == '0) ? lwu_pkg::TGT_W'(1) : target_q;
  assign ps_eff      = (ps_q == '0) ? lwu_pkg::PS_W'(1) : ps_q;
  assign psn_val     = (func_i == lwu_pkg::FUNC_ACK) ? psn_i - lwu_pkg::PSN_W'(1) : psn_i;

  // Delay and RTT from the send time just read.
  assign delay_w = (stamp_q > send_rd_q) ? stamp_q - send_rd_q : '0;
  assign rtt_w   = (now_q > send_rd_q) ? now_q - send_rd_q : '0;

  // Filter length clamped to 2..FILTER_DEPTH; the window keeps one less.
  always_comb begin
    if (flen_q < lwu_pkg::FLEN_W'(2)) begin
      len7 = 7'd2;
    end else if (7'(flen_q) > 7'(FILTER_DEPTH)) begin
      len7 = 7'(FILTER_DEPTH);
    end else begin
      len7 = 7'(flen_q);
    end
    keep    = (CW + 1)'(len7 - 7'd1);
    cnt_inc = {1'b0, cnt_q} + (CW + 1)'(1);
  end

  // Filter read address: newest entries first, walking back from the head.
  assign win_raddr = (HW'(scan_q) <= wbase_q)
                     ? wbase_q - HW'(scan_q)
                     : HW'((HW + 1)'(wbase_q) + (HW + 1)'(FILTER_DEPTH)
                           - (HW + 1)'(scan_q));

  assign ref_w     = lwu_pkg::REF_W'(tgt_eff) + lwu_pkg::REF_W'(base_q);
  assign pk_num    = lwu_pkg::PKNUM_W'(cwnd_q) + lwu_pkg::PKNUM_W'(ps_eff)
                     - lwu_pkg::PKNUM_W'(1);
  assign floor_ext = lwu_pkg::NEXT_W'(floor_q);

  // New window before flooring and saturation.
  always_comb begin
    if (neg_q) begin
      next_w = (lwu_pkg::DELTA_W'(cwnd_q) > delta_q)
               ? lwu_pkg::NEXT_W'(lwu_pkg::DELTA_W'(cwnd_q) - delta_q) : '0;
    end else begin
      next_w = lwu_pkg::NEXT_W'(cwnd_q) + lwu_pkg::NEXT_W'(delta_q);
    end
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    now_d     = now_q;
    stamp_d   = stamp_q;
    idx_d     = idx_q;
    rtt_d     = rtt_q;
    best_d    = best_q;
    head_d    = head_q;
    wbase_d   = wbase_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    pkts_d    = pkts_q;
    gp_d      = gp_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    num_d     = num_q;
    floor_d   = floor_q;
    delta_d   = delta_q;
    cwnd_d    = cwnd_q;
    out_load  = 1'b0;
    send_we   = 1'b0;
    send_re   = 1'b0;
    win_we    = 1'b0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    div_iters = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      lwu_pkg::ST_IDLE: begin
        if (accept) begin
          func_d  = func_i;
          now_d   = now_ns_i;
          stamp_d = ack_stamp_ns_i;
          if (POW2) begin
            idx_d   = psn_val[IW-1:0];
            state_d = lwu_pkg::ST_ACCESS;
          end else begin
            div_start = 1'b1;
            div_n     = DW'(psn_val) << (DW - lwu_pkg::PSN_W);
            div_d     = DW'(SEND_TABLE_DEPTH);
            div_iters = ITW'(lwu_pkg::PSN_W);
            state_d   = lwu_pkg::ST_MOD;
          end
        end
      end
      lwu_pkg::ST_MOD: begin
        if (div_done) begin
          idx_d   = div_r[IW-1:0];
          state_d = lwu_pkg::ST_ACCESS;
        end
      end
      lwu_pkg::ST_ACCESS: begin
        if (func_q == lwu_pkg::FUNC_SEND) begin
          send_we = 1'b1;
          state_d = lwu_pkg::ST_IDLE;
        end else begin
          send_re = 1'b1;
          state_d = lwu_pkg::ST_SENDRD;
        end
      end
      lwu_pkg::ST_SENDRD: begin
        // Store the new delay and set up the walk over older entries.
        win_we  = 1'b1;
        rtt_d   = rtt_w;
        best_d  = delay_w;
        wbase_d = head_q;
        head_d  = (head_q == HW'(FILTER_DEPTH - 1)) ? '0 : head_q + HW'(1);
        cnt_d   = (cnt_inc > keep) ? keep[CW-1:0] : cnt_inc[CW-1:0];
        scan_d  = CW'(1);
        pend_d  = 1'b0;
        state_d = lwu_pkg::ST_SCAN;
      end
      lwu_pkg::ST_SCAN: begin
        if (pend_q && (win_rd_q < best_q)) begin
          best_d = win_rd_q;
        end
        if (scan_q < cnt_q) begin
          pend_d = 1'b1;
          scan_d = scan_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = lwu_pkg::ST_PKTS_GO;
          end
        end
      end
      lwu_pkg::ST_PKTS_GO: begin
        // Packet count ceil(cwnd / ps) on the divider; offset magnitude here.
        div_start = 1'b1;
        div_n     = DW'(pk_num) << (DW - lwu_pkg::PKNUM_W);
        div_d     = DW'(ps_eff);
        div_iters = ITW'(lwu_pkg::PKNUM_W);
        gp_d      = gain_q * ps_eff;
        if (MAGW'(best_q) <= MAGW'(ref_w)) begin
          neg_d = 1'b0;
          mag_d = MAGW'(ref_w) - MAGW'(best_q);
        end else begin
          neg_d = 1'b1;
          mag_d = MAGW'(best_q) - MAGW'(ref_w);
        end
        state_d = lwu_pkg::ST_PKTS;
      end
      lwu_pkg::ST_PKTS: begin
        if (div_done) begin
          pkts_d    = (div_q == '0) ? lwu_pkg::CWND_W'(1) : div_q[lwu_pkg::CWND_W-1:0];
          mul_start = 1'b1;
          mul_a     = DW'(mag_q);
          mul_b     = lwu_pkg::MUL_B_W'(gp_q);
          state_d   = lwu_pkg::ST_MUL_NUM;
        end
      end
      lwu_pkg::ST_MUL_NUM: begin
        floor_d = minc_q * ps_eff;
        if (mul_done) begin
          num_d     = mul_p;
          mul_start = 1'b1;
          mul_a     = DW'(tgt_eff) << 8;
          mul_b     = pkts_q;
          state_d   = lwu_pkg::ST_MUL_DEN;
        end
      end
      lwu_pkg::ST_MUL_DEN: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = num_q << (DW - NUMW);
          div_d     = mul_p;
          div_iters = ITW'(NUMW);
          state_d   = lwu_pkg::ST_DIV;
        end
      end
      lwu_pkg::ST_DIV: begin
        if (div_done) begin
          delta_d = (div_q > DW'(lwu_pkg::DELTA_CLAMP))
                    ? lwu_pkg::DELTA_CLAMP : div_q[lwu_pkg::DELTA_W-1:0];
          state_d = lwu_pkg::ST_UPD;
        end
      end
      lwu_pkg::ST_UPD: begin
        if (next_w < floor_ext) begin
          cwnd_d = lwu_pkg::CWND_W'(floor_q);
        end else if (next_w > lwu_pkg::NEXT_W'(lwu_pkg::CWND_MAX)) begin
          cwnd_d = lwu_pkg::CWND_MAX;
        end else begin
          cwnd_d = next_w[lwu_pkg::CWND_W-1:0];
        end
        state_d = lwu_pkg::ST_OUT;
      end
      lwu_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = lwu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lwu_pkg::ST_IDLE;
      end
    endcase
    // Initial window writes reload cwnd; user keeps them to idle, unenforced.
    if (cfg_valid_i && cfg_ready_o && (cfg_index_i == lwu_pkg::CFG_INIT)) begin
      cwnd_d = cfg_data_i[lwu_pkg::CWND_W-1:0];
    end
  end

  // State register and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwu_pkg::ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      cwnd_q      <= lwu_pkg::INIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      cwnd_q  <= cwnd_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    now_q   <= now_d;
    stamp_q <= stamp_d;
    idx_q   <= idx_d;
    rtt_q   <= rtt_d;
    best_q  <= best_d;
    wbase_q <= wbase_d;
    pkts_q  <= pkts_d;
    gp_q    <= gp_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    num_q   <= num_d;
    floor_q <= floor_d;
    delta_q <= delta_d;
    if (out_load) begin
      out_cwnd_q <= cwnd_q;
      out_rtt_q  <= rtt_q;
      out_filt_q <= best_q;
    end
  end

  // Configuration registers. The initial window lives only in the window
  // register, which the sequencer reloads on a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= lwu_pkg::TARGET_RST;
      gain_q   <= lwu_pkg::GAIN_RST;
      minc_q   <= lwu_pkg::MINC_RST;
      flen_q   <= lwu_pkg::FLEN_RST;
      base_q   <= lwu_pkg::BASE_RST;
      ps_q     <= lwu_pkg::PS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lwu_pkg::CFG_TARGET: target_q <= cfg_data_i[lwu_pkg::TGT_W-1:0];
        lwu_pkg::CFG_GAIN:   gain_q   <= cfg_data_i[lwu_pkg::GAIN_W-1:0];
        lwu_pkg::CFG_MINC:   minc_q   <= cfg_data_i[lwu_pkg::MINC_W-1:0];
        lwu_pkg::CFG_FLEN:   flen_q   <= cfg_data_i[lwu_pkg::FLEN_W-1:0];
        lwu_pkg::CFG_BASE:   base_q   <= cfg_data_i[lwu_pkg::BASE_W-1:0];
        lwu_pkg::CFG_PS:     ps_q     <= cfg_data_i[lwu_pkg::PS_W-1:0];
        default: ;
      endcase
    end
  end

  // Send time table: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (send_we) begin
      send_mem[idx_q] <= now_q;
    end
    if (send_re) begin
      send_rd_q <= send_mem[idx_q];
    end
  end

  // Delay filter memory: write at the head, registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[head_q] <= delay_w;
    end
    win_rd_q <= win_mem[win_raddr];
  end

  assign out_valid_o         = out_valid_q;
  assign cwnd_bytes_o        = out_cwnd_q;
  assign rtt_ns_o            = out_rtt_q;
  assign filtered_delay_ns_o = out_filt_q;

endmodule
